// ----- sv/tesd_pkg.sv -----
// Shared types and constants for the touch event slot decoder.
// No dependencies; imported by every module of the block.
package tesd_pkg;

	localparam int SLOT_COUNT  = 10;
	localparam int FIFO_DEPTH  = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam int CNT_W  = $clog2(FIFO_DEPTH);
	localparam int STEP_W = $clog2(SLOT_COUNT + 3);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// event ids (head byte bits 1-0)
	localparam logic [1:0] EVID_COORD  = 2'd0;
	localparam logic [1:0] EVID_STATUS = 2'd1;

	// coordinate actions (head byte bits 7-6)
	localparam logic [1:0] ACT_PRESS   = 2'd1;
	localparam logic [1:0] ACT_MOVE    = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	// touch types
	localparam logic [3:0] TTYPE_NORMAL = 4'd0;
	localparam logic [3:0] TTYPE_GLOVE  = 4'd3;
	localparam logic [3:0] TTYPE_PALM   = 4'd5;
	localparam logic [3:0] TTYPE_WET    = 4'd6;

	// status events
	localparam logic [3:0] STYPE_ERROR          = 4'd1;
	localparam logic [7:0] ERR_EVENT_QUEUE_FULL = 8'h01;
	localparam logic [7:0] ERR_EVENT_ESD        = 8'h02;

	// configuration register indexes
	localparam logic [2:0] REG_PANEL_MAX_X = 3'd0;
	localparam logic [2:0] REG_PANEL_MAX_Y = 3'd1;
	localparam logic [2:0] REG_INVERT_X    = 3'd2;
	localparam logic [2:0] REG_INVERT_Y    = 3'd3;
	localparam logic [2:0] REG_SWAP_XY     = 3'd4;

	typedef enum logic [1:0] {
		KIND_ACTIVE   = 2'd0,
		KIND_INACTIVE = 2'd1,
		KIND_SYNC     = 2'd2,
		KIND_ALARM    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_ACTIVE   = 3'd1,
		OP_INACTIVE = 3'd2,
		OP_QFULL    = 3'd3,
		OP_ALARM    = 3'd4
	} op_t;

	typedef struct packed {
		logic        swap_xy;
		logic        invert_y;
		logic        invert_x;
		logic [11:0] panel_max_y;
		logic [11:0] panel_max_x;
	} cfg_t;

	// one classified event on its way to the back end
	typedef struct packed {
		op_t         op;
		logic        end_batch;
		logic [3:0]  slot;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  touch_major;
		logic [7:0]  touch_minor;
	} cmd_t;

endpackage

// ----- sv/tesd_front.sv -----
// Front end: batch counting and event classification.
// Depends on tesd_pkg.
module tesd_front
	import tesd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  cfg_t       cfg,
	input  logic [7:0] head_byte,
	input  logic [7:0] info_byte,
	input  logic [7:0] y_high_byte,
	input  logic [7:0] xy_low_byte,
	input  logic [7:0] major_byte,
	input  logic [7:0] minor_byte,
	input  logic [7:0] type_high_byte,
	input  logic [7:0] tail_byte,
	output logic       push,
	output cmd_t       cmd
);

	logic [CNT_W-1:0] remain_q;
	logic             in_batch_q;
	logic [CNT_W-1:0] remain_nxt;
	logic [6:0]       raw_cnt;
	logic             end_batch;

	logic [1:0]  evid;
	logic [3:0]  tid;
	logic [1:0]  action;
	logic [3:0]  ttype;
	logic [11:0] x_raw, y_raw, x_inv, y_inv;
	logic        tid_ok, ttype_ok;

	assign raw_cnt = {1'b0, tail_byte[5:0]};

	always_comb begin
		if (!in_batch_q) begin
			if (raw_cnt >= 7'(FIFO_DEPTH)) begin
				remain_nxt = CNT_W'(FIFO_DEPTH - 1);
			end else begin
				remain_nxt = CNT_W'(raw_cnt);
			end
		end else begin
			// inside a batch the count is at least one
			remain_nxt = remain_q - CNT_W'(1);
		end
		end_batch = (remain_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= '0;
			in_batch_q <= 1'b0;
		end else if (accept) begin
			remain_q   <= remain_nxt;
			in_batch_q <= !end_batch;
		end
	end

	assign evid   = head_byte[1:0];
	assign tid    = head_byte[5:2];
	assign action = head_byte[7:6];
	assign ttype  = {type_high_byte[7:6], tail_byte[7:6]};
	assign x_raw  = {info_byte, xy_low_byte[7:4]};
	assign y_raw  = {y_high_byte, xy_low_byte[3:0]};

	assign tid_ok   = ({1'b0, tid} < 5'(SLOT_COUNT));
	assign ttype_ok = (ttype == TTYPE_NORMAL) || (ttype == TTYPE_GLOVE) ||
	                  (ttype == TTYPE_PALM) || (ttype == TTYPE_WET);

	// mirror clamps at zero
	assign x_inv = !cfg.invert_x ? x_raw :
	               (cfg.panel_max_x > x_raw) ? cfg.panel_max_x - x_raw : 12'd0;
	assign y_inv = !cfg.invert_y ? y_raw :
	               (cfg.panel_max_y > y_raw) ? cfg.panel_max_y - y_raw : 12'd0;

	always_comb begin
		cmd             = '0;
		cmd.op          = OP_NONE;
		cmd.end_batch   = end_batch;
		cmd.slot        = tid;
		unique case (evid)
			EVID_COORD: begin
				if (tid_ok && ttype_ok) begin
					if (action == ACT_PRESS || action == ACT_MOVE) begin
						cmd.op          = OP_ACTIVE;
						cmd.pos_x       = cfg.swap_xy ? y_inv : x_inv;
						cmd.pos_y       = cfg.swap_xy ? x_inv : y_inv;
						cmd.touch_major = major_byte;
						cmd.touch_minor = minor_byte;
					end else if (action == ACT_RELEASE) begin
						cmd.op = OP_INACTIVE;
					end
				end
			end
			EVID_STATUS: begin
				if (tid == STYPE_ERROR) begin
					if (info_byte == ERR_EVENT_QUEUE_FULL) begin
						cmd.op = OP_QFULL;
					end else if (info_byte == ERR_EVENT_ESD) begin
						cmd.op = OP_ALARM;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// events that give no result are dropped here
	assign push = accept && ((cmd.op != OP_NONE) || end_batch);

endmodule

// ----- sv/tesd_queue.sv -----
// Short command queue between the front and back ends.
// Depends on tesd_pkg (cmd_t, QUEUE_DEPTH).
module tesd_queue
	import tesd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/tesd_back.sv -----
// Back end: expands commands into result items, keeps the slot mask,
// and holds the output register. Depends on tesd_pkg.
module tesd_back
	import tesd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  report_kind,
	output logic [3:0]  slot,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [7:0]  touch_major,
	output logic [7:0]  touch_minor,
	output logic [9:0]  active_mask,
	output logic        last
);

	logic [STEP_W-1:0]     step_q;
	logic [SLOT_COUNT-1:0] mask_q;
	logic                  valid_q;

	logic [STEP_W-1:0]     n_body, n_total;
	logic                  emit, step_last, in_body;
	kind_t                 kind_c;
	logic [3:0]            slot_c;
	logic [SLOT_COUNT-1:0] slot_bit, mask_nxt;
	logic [11:0]           x_c, y_c;
	logic [7:0]            maj_c, min_c;
	logic [9:0]            rmask_c;

	always_comb begin
		unique case (cmd.op)
			OP_ACTIVE, OP_INACTIVE, OP_ALARM: n_body = STEP_W'(1);
			OP_QFULL:                         n_body = STEP_W'(SLOT_COUNT + 1);
			default:                          n_body = '0;
		endcase
	end

	assign n_total   = n_body + STEP_W'(cmd.end_batch);
	assign step_last = (step_q == n_total - STEP_W'(1));
	assign in_body   = (step_q < n_body);
	assign emit      = cmd_valid && (!valid_q || out_ready);
	assign pop       = emit && step_last;
	assign slot_bit  = SLOT_COUNT'(1) << cmd.slot;

	always_comb begin
		kind_c   = KIND_SYNC;
		slot_c   = '0;
		x_c      = '0;
		y_c      = '0;
		maj_c    = '0;
		min_c    = '0;
		mask_nxt = mask_q;
		if (in_body) begin
			unique case (cmd.op)
				OP_ACTIVE: begin
					kind_c   = KIND_ACTIVE;
					slot_c   = cmd.slot;
					x_c      = cmd.pos_x;
					y_c      = cmd.pos_y;
					maj_c    = cmd.touch_major;
					min_c    = cmd.touch_minor;
					mask_nxt = mask_q | slot_bit;
				end
				OP_INACTIVE: begin
					kind_c   = KIND_INACTIVE;
					slot_c   = cmd.slot;
					mask_nxt = mask_q & ~slot_bit;
				end
				OP_ALARM: begin
					kind_c = KIND_ALARM;
				end
				OP_QFULL: begin
					// release every slot, then a sync that clears the mask
					if (step_q < STEP_W'(SLOT_COUNT)) begin
						kind_c = KIND_INACTIVE;
						slot_c = 4'(step_q);
					end else begin
						mask_nxt = '0;
					end
				end
				default: begin
				end
			endcase
		end
		// sync items carry the zero-extended mask, the QFULL sync reports zero
		rmask_c = (kind_c == KIND_SYNC && !(cmd.op == OP_QFULL && in_body)) ?
		          10'(mask_q) : 10'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				mask_q  <= mask_nxt;
				step_q  <= step_last ? '0 : step_q + STEP_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report_kind <= kind_c;
			slot        <= slot_c;
			pos_x       <= x_c;
			pos_y       <= y_c;
			touch_major <= maj_c;
			touch_minor <= min_c;
			active_mask <= rmask_c;
			last        <= step_last;
		end
	end

	assign out_valid = valid_q;

endmodule

// ----- sv/touch_event_slot_decoder.sv -----
// Top level of the touch event slot decoder: configuration registers,
// front end, command queue and back end. Depends on tesd_pkg and all tesd_ modules.
//
// Takes one touch-controller event record per item (its first eight bytes)
// and turns it into multitouch slot reports. The front end counts events in
// the current batch (the first event's tail byte gives how many follow,
// clamped to 31), decodes the record, applies inversion and swap, and drops
// events that give no result. It accepts an item in any cycle in which the
// four-entry command queue has room, so items can arrive back to back.
// The back end turns each queued command into its results at one result per
// cycle while out_ready takes them, through a registered output:
// press/move/release/alarm give one, a queue-full error gives eleven (ten
// releases and a sync), and the last event of a batch adds a frame sync
// carrying the active-slot mask. An item thus gives from 0 to 12 results,
// and that output port is what bounds sustained throughput. The "last" flag
// marks the final result of each item. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and should change only while idle.
module touch_event_slot_decoder
	import tesd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  head_byte,
	input  logic [7:0]  info_byte,
	input  logic [7:0]  y_high_byte,
	input  logic [7:0]  xy_low_byte,
	input  logic [7:0]  major_byte,
	input  logic [7:0]  minor_byte,
	input  logic [7:0]  type_high_byte,
	input  logic [7:0]  tail_byte,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  report_kind,
	output logic [3:0]  slot,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [7:0]  touch_major,
	output logic [7:0]  touch_minor,
	output logic [9:0]  active_mask,
	output logic        last
);

	cfg_t cfg_q;
	logic accept, push, pop, q_full, q_empty;
	cmd_t front_cmd, head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_max_x <= 12'hfff;
			cfg_q.panel_max_y <= 12'hfff;
			cfg_q.invert_x    <= 1'b0;
			cfg_q.invert_y    <= 1'b0;
			cfg_q.swap_xy     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PANEL_MAX_X: cfg_q.panel_max_x <= cfg_data;
				REG_PANEL_MAX_Y: cfg_q.panel_max_y <= cfg_data;
				REG_INVERT_X:    cfg_q.invert_x    <= cfg_data[0];
				REG_INVERT_Y:    cfg_q.invert_y    <= cfg_data[0];
				REG_SWAP_XY:     cfg_q.swap_xy     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// an item is taken whenever the queue can hold its command
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	tesd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cfg            (cfg_q),
		.head_byte      (head_byte),
		.info_byte      (info_byte),
		.y_high_byte    (y_high_byte),
		.xy_low_byte    (xy_low_byte),
		.major_byte     (major_byte),
		.minor_byte     (minor_byte),
		.type_high_byte (type_high_byte),
		.tail_byte      (tail_byte),
		.push           (push),
		.cmd            (front_cmd)
	);

	tesd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	tesd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!q_empty),
		.cmd         (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.report_kind (report_kind),
		.slot        (slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.touch_major (touch_major),
		.touch_minor (touch_minor),
		.active_mask (active_mask),
		.last        (last)
	);

endmodule
